// ===== rtl/core/bhs_pkg.sv =====
// types and constants shared by the hue and saturation pipeline
package bhs_pkg;

	localparam int CHAN_W = 16;
	localparam int HUE_W  = 17;
	localparam int SAT_W  = 17;
	localparam int BASE_W = 15;
	localparam int IDX_W  = 8;
	localparam int DATA_W = 16;

	// quotient bits of both dividers, enough for a sat quotient of 65536
	localparam int QUOT_W   = 17;
	localparam int HNUM_W   = 28;
	localparam int SNUM_W   = 32;

	localparam logic [IDX_W-1:0] REG_BASE_LEVEL      = 8'd0;
	localparam logic [IDX_W-1:0] REG_NEAR_ZERO_LIMIT = 8'd1;

	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	localparam logic signed [HUE_W-1:0] HUE_BASE_GREEN = 17'sd7680;
	localparam logic signed [HUE_W-1:0] HUE_BASE_BLUE  = -17'sd7680;
	localparam logic signed [HUE_W-1:0] HUE_HALF_TURN  = 17'sd11520;
	localparam logic signed [HUE_W-1:0] HUE_FULL_TURN  = 17'sd23040;
	localparam logic [SAT_W-1:0]        SAT_ONE        = 17'd65536;

	localparam logic [BASE_W-1:0] BASE_LEVEL_RST = 15'd0;
	localparam logic [CHAN_W-1:0] NEAR_ZERO_RST  = 16'd1;

	typedef struct packed {
		logic [1:0] sec;
		logic       neg;
		logic       rz;
		logic       undef;
		logic       satz;
	} side_t;

endpackage

// ===== rtl/core/bhs_ifs.sv =====
// pixel, result and register write channels

interface bhs_pix_if;
	logic                         valid;
	logic                         ready;
	logic [bhs_pkg::CHAN_W-1:0]   chan_blue;
	logic [bhs_pkg::CHAN_W-1:0]   chan_green;
	logic [bhs_pkg::CHAN_W-1:0]   chan_red;

	modport source (output valid, chan_blue, chan_green, chan_red, input ready);
	modport sink   (input valid, chan_blue, chan_green, chan_red, output ready);
endinterface

interface bhs_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [bhs_pkg::HUE_W-1:0]   hue_deg;
	logic [bhs_pkg::SAT_W-1:0]          sat_frac;
	logic                               hue_undefined;

	modport source (output valid, hue_deg, sat_frac, hue_undefined, input ready);
	modport sink   (input valid, hue_deg, sat_frac, hue_undefined, output ready);
endinterface

interface bhs_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [bhs_pkg::IDX_W-1:0]    index;
	logic [bhs_pkg::DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bhs_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module bhs_div #(
	parameter int NW = 32,
	parameter int QW = 17
) (
	input  logic                        clk,
	input  logic [QW-1:0]               en,
	input  logic [NW-1:0]               num,
	input  logic [bhs_pkg::CHAN_W-1:0]  den,
	output logic [QW-1:0]               quot
);

	localparam int RW = bhs_pkg::CHAN_W;

	logic [RW-1:0] rem_s [QW];
	logic [QW-1:0] wq_s  [QW];
	logic [RW-1:0] den_s [QW];

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_step
			logic [RW-1:0] rem_in;
			logic [QW-1:0] wq_in;
			logic [RW-1:0] den_in;
			logic [RW:0]   trial;
			logic [RW:0]   trial_sub;
			logic          ge;

			if (k == 0) begin : g_first
				assign rem_in = RW'(num[NW-1:QW]);
				assign wq_in  = num[QW-1:0];
				assign den_in = den;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign wq_in  = wq_s[k-1];
				assign den_in = den_s[k-1];
			end

			assign trial     = {rem_in, wq_in[QW-1]};
			assign ge        = trial >= {1'b0, den_in};
			assign trial_sub = trial - {1'b0, den_in};

			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= ge ? trial_sub[RW-1:0] : trial[RW-1:0];
					wq_s[k]  <= {wq_in[QW-2:0], ge};
					den_s[k] <= den_in;
				end
			end
		end
	endgenerate

	assign quot = wq_s[QW-1];

endmodule

// ===== rtl/core/bgr_hue_saturation.sv =====
// hue and saturation of one blue, green, red pixel
// an input transfer passes s1 to s4, the divider stages, s5 and s6 before its result is valid
// one pixel per cycle while the output is not stalled; two 17-stage dividers set the depth
// a stalled output holds its result while bubbles ahead of it still fill
// arst_n clears all valid bits and loads base_level 0, near_zero_limit 1
module bgr_hue_saturation (
	input  logic        clk,
	input  logic        arst_n,
	bhs_cfg_if.sink     cfg,
	bhs_pix_if.sink     pix,
	bhs_res_if.source   res
);

	localparam int NDIV = bhs_pkg::QUOT_W;

	logic signed [bhs_pkg::BASE_W-1:0] base_level_q;
	logic [bhs_pkg::CHAN_W-1:0]        limit_q;

	// enables
	logic            en1, en2, en3, en4, en5, en6;
	logic [NDIV-1:0] en_div;

	// stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [NDIV-1:0] v_div;

	logic [bhs_pkg::CHAN_W-1:0] b_s1, g_s1, r_s1;

	logic [bhs_pkg::CHAN_W-1:0] mx_s2, mn_s2, pa_s2, pb_s2;
	logic [1:0]                 sec_s2;

	logic [bhs_pkg::CHAN_W-1:0] mx_s3, mn_s3, range_s3;
	logic signed [bhs_pkg::CHAN_W:0] diff_s3;
	logic [1:0]                 sec_s3;

	logic [bhs_pkg::HNUM_W-1:0] hnum_s4;
	logic [bhs_pkg::SNUM_W-1:0] snum_s4;
	logic [bhs_pkg::CHAN_W-1:0] hden_s4, sden_s4;
	bhs_pkg::side_t             side_s4;

	bhs_pkg::side_t side_div [NDIV];

	logic signed [bhs_pkg::HUE_W-1:0] hue_s5, hue_wrap_s5;
	logic [bhs_pkg::SAT_W-1:0]        sat_s5;
	logic                             undef_s5;

	logic signed [bhs_pkg::HUE_W-1:0] hue_s6;
	logic [bhs_pkg::SAT_W-1:0]        sat_s6;
	logic                             undef_s6;

	// combinational
	logic [bhs_pkg::CHAN_W-1:0] mx_c, mn_c, pa_c, pb_c;
	logic [1:0]                 sec_c;
	logic [bhs_pkg::CHAN_W-1:0] mag_c;
	logic [bhs_pkg::HNUM_W-1:0] hnum_c;
	logic [bhs_pkg::QUOT_W-1:0] hq, sq;
	logic [11:0]                off_c;
	logic signed [bhs_pkg::HUE_W-1:0] soff_c, base_c, hue_c, thr_c;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_level_q <= bhs_pkg::BASE_LEVEL_RST;
			limit_q      <= bhs_pkg::NEAR_ZERO_RST;
		end else if (cfg.valid) begin
			if (cfg.index == bhs_pkg::REG_BASE_LEVEL) begin
				base_level_q <= cfg.data[bhs_pkg::BASE_W-1:0];
			end
			if (cfg.index == bhs_pkg::REG_NEAR_ZERO_LIMIT) begin
				limit_q <= cfg.data;
			end
		end
	end

	// ready chain, each stage moves when empty or when the next one moves
	assign en6 = !v_s6 || res.ready;
	assign en5 = !v_s5 || en6;
	assign en_div[NDIV-1] = !v_div[NDIV-1] || en5;
	genvar k;
	generate
		for (k = 0; k < NDIV - 1; k++) begin : g_en
			assign en_div[k] = !v_div[k] || en_div[k+1];
		end
	endgenerate
	assign en4 = !v_s4 || en_div[0];
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pix.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_div <= '0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
		end else begin
			if (en1) v_s1 <= pix.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en_div[0]) v_div[0] <= v_s4;
			for (int i = 1; i < NDIV; i++) begin
				if (en_div[i]) v_div[i] <= v_div[i-1];
			end
			if (en5) v_s5 <= v_div[NDIV-1];
			if (en6) v_s6 <= v_s5;
		end
	end

	// s1: input capture
	always_ff @(posedge clk) begin
		if (en1) begin
			b_s1 <= pix.chan_blue;
			g_s1 <= pix.chan_green;
			r_s1 <= pix.chan_red;
		end
	end

	// s2: max, min and sector
	always_comb begin
		mx_c = b_s1;
		mn_c = b_s1;
		if (g_s1 > mx_c) mx_c = g_s1;
		if (r_s1 > mx_c) mx_c = r_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (r_s1 < mn_c) mn_c = r_s1;
		priority if (r_s1 == mx_c) begin
			sec_c = bhs_pkg::SEC_RED;
			pa_c  = g_s1;
			pb_c  = b_s1;
		end else if (g_s1 == mx_c) begin
			sec_c = bhs_pkg::SEC_GREEN;
			pa_c  = b_s1;
			pb_c  = r_s1;
		end else begin
			sec_c = bhs_pkg::SEC_BLUE;
			pa_c  = r_s1;
			pb_c  = g_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			mx_s2  <= mx_c;
			mn_s2  <= mn_c;
			pa_s2  <= pa_c;
			pb_s2  <= pb_c;
			sec_s2 <= sec_c;
		end
	end

	// s3: range and channel difference
	always_ff @(posedge clk) begin
		if (en3) begin
			mx_s3    <= mx_s2;
			mn_s3    <= mn_s2;
			range_s3 <= mx_s2 - mn_s2;
			diff_s3  <= $signed({1'b0, pa_s2}) - $signed({1'b0, pb_s2});
			sec_s3   <= sec_s2;
		end
	end

	// s4: magnitude times sixty degrees, flags
	assign mag_c  = diff_s3[bhs_pkg::CHAN_W] ? bhs_pkg::CHAN_W'(-diff_s3)
	                                         : diff_s3[bhs_pkg::CHAN_W-1:0];
	assign hnum_c = {mag_c, 12'd0} - {4'd0, mag_c, 8'd0};

	always_ff @(posedge clk) begin
		if (en4) begin
			hnum_s4       <= hnum_c;
			snum_s4       <= {mn_s3, 16'd0};
			hden_s4       <= range_s3;
			sden_s4       <= mx_s3;
			side_s4.sec   <= sec_s3;
			side_s4.neg   <= diff_s3[bhs_pkg::CHAN_W];
			side_s4.rz    <= range_s3 == '0;
			side_s4.undef <= range_s3 < limit_q;
			side_s4.satz  <= (mx_s3 < limit_q) || (mx_s3 == '0);
		end
	end

	bhs_div #(
		.NW (bhs_pkg::HNUM_W),
		.QW (NDIV)
	) u_hue_div (
		.clk  (clk),
		.en   (en_div),
		.num  (hnum_s4),
		.den  (hden_s4),
		.quot (hq)
	);

	bhs_div #(
		.NW (bhs_pkg::SNUM_W),
		.QW (NDIV)
	) u_sat_div (
		.clk  (clk),
		.en   (en_div),
		.num  (snum_s4),
		.den  (sden_s4),
		.quot (sq)
	);

	always_ff @(posedge clk) begin
		if (en_div[0]) side_div[0] <= side_s4;
		for (int i = 1; i < NDIV; i++) begin
			if (en_div[i]) side_div[i] <= side_div[i-1];
		end
	end

	// s5: sector base plus signed offset, saturation
	assign off_c  = side_div[NDIV-1].rz ? 12'd0 : hq[11:0];
	assign soff_c = side_div[NDIV-1].neg ? -$signed({5'd0, off_c})
	                                     : $signed({5'd0, off_c});

	always_comb begin
		unique case (side_div[NDIV-1].sec)
			bhs_pkg::SEC_GREEN: base_c = bhs_pkg::HUE_BASE_GREEN;
			bhs_pkg::SEC_BLUE:  base_c = bhs_pkg::HUE_BASE_BLUE;
			default:            base_c = '0;
		endcase
	end

	assign hue_c = base_c + soff_c;

	always_ff @(posedge clk) begin
		if (en5) begin
			hue_s5      <= hue_c;
			hue_wrap_s5 <= hue_c + bhs_pkg::HUE_FULL_TURN;
			sat_s5      <= side_div[NDIV-1].satz ? '0 : bhs_pkg::SAT_ONE - sq;
			undef_s5    <= side_div[NDIV-1].undef;
		end
	end

	// s6: wrap test and output register
	assign thr_c = bhs_pkg::HUE_W'(base_level_q) - bhs_pkg::HUE_HALF_TURN;

	always_ff @(posedge clk) begin
		if (en6) begin
			priority if (undef_s5) begin
				hue_s6 <= '0;
			end else if (hue_s5 < thr_c) begin
				hue_s6 <= hue_wrap_s5;
			end else begin
				hue_s6 <= hue_s5;
			end
			sat_s6   <= sat_s5;
			undef_s6 <= undef_s5;
		end
	end

	assign res.valid         = v_s6;
	assign res.hue_deg       = hue_s6;
	assign res.sat_frac      = sat_s6;
	assign res.hue_undefined = undef_s6;

endmodule

// ===== rtl/core/bhs_check.sv =====
// port checker for the hue and saturation block, with its bind
module bhs_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               res_valid,
	input  logic                               res_ready,
	input  logic signed [bhs_pkg::HUE_W-1:0]   res_hue_deg,
	input  logic [bhs_pkg::SAT_W-1:0]          res_sat_frac,
	input  logic                               res_hue_undefined
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_hue_deg) &&
		$stable(res_sat_frac) && $stable(res_hue_undefined))
		else $error("result changed while stalled");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_hue_undefined |-> res_hue_deg == '0)
		else $error("undefined hue not zero");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_sat_frac <= bhs_pkg::SAT_ONE)
		else $error("saturation above one");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_hue_deg >= -bhs_pkg::HUE_HALF_TURN &&
		res_hue_deg <= bhs_pkg::HUE_HALF_TURN + bhs_pkg::HUE_FULL_TURN)
		else $error("hue out of range");

endmodule

bind bgr_hue_saturation bhs_check u_bhs_check (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_hue_deg       (res.hue_deg),
	.res_sat_frac      (res.sat_frac),
	.res_hue_undefined (res.hue_undefined)
);
